// ===== sv/date_to_day_number_defines.svh =====
// ----------------------------------------------------------------------------
// date_to_day_number_defines
// assertion macros shared by the date to day number block
// ----------------------------------------------------------------------------
`ifndef DATE_TO_DAY_NUMBER_DEFINES_SVH
`define DATE_TO_DAY_NUMBER_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define DTDN_CHECK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define DTDN_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// antecedent implies a later consequent
`define DTDN_CHECK_AFTER2(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// ===== sv/dtdn_pkg.sv =====
// ----------------------------------------------------------------------------
// dtdn_pkg
// types, constants and tables for the date to day number block
// ----------------------------------------------------------------------------
package dtdn_pkg;

  localparam int unsigned DEF_BASE_YEAR = 1900;
  localparam int unsigned DEF_YEAR_SPAN = 256;

  localparam int unsigned YEAR_W   = 12;
  localparam int unsigned MONTH_W  = 4;
  localparam int unsigned DAY_W    = 5;
  localparam int unsigned NUMBER_W = 17;
  localparam int unsigned MSTART_W = 9;

  localparam int unsigned ROM_YEARS = 256;
  localparam int unsigned ROM_AW    = $clog2(ROM_YEARS);

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

  // divide by 25 through a reciprocal, exact for any 12-bit year
  localparam logic [12:0] RECIP_25  = 13'd5243;
  localparam int unsigned RECIP_SH  = 17;
  localparam logic [4:0]  DIVISOR_25 = 5'd25;

  // registered result of the check stage
  typedef struct packed {
    logic                valid;
    logic                ok;
    logic [MSTART_W-1:0] mstart;
    logic [DAY_W-1:0]    day;
  } chk_t;

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1:    len = 5'd31;
      4'd2:    len = 5'd28;
      4'd3:    len = 5'd31;
      4'd4:    len = 5'd30;
      4'd5:    len = 5'd31;
      4'd6:    len = 5'd30;
      4'd7:    len = 5'd31;
      4'd8:    len = 5'd31;
      4'd9:    len = 5'd30;
      4'd10:   len = 5'd31;
      4'd11:   len = 5'd30;
      4'd12:   len = 5'd31;
      default: len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
    logic [MSTART_W-1:0] s;
    case (m)
      4'd1:    s = 9'h000;
      4'd2:    s = 9'h01F;
      4'd3:    s = 9'h03B;
      4'd4:    s = 9'h05A;
      4'd5:    s = 9'h078;
      4'd6:    s = 9'h097;
      4'd7:    s = 9'h0B5;
      4'd8:    s = 9'h0D4;
      4'd9:    s = 9'h0F3;
      4'd10:   s = 9'h111;
      4'd11:   s = 9'h130;
      4'd12:   s = 9'h14E;
      default: s = 9'h000;
    endcase
    return s;
  endfunction

  // per-year start serials, kept as supplied
  localparam logic [NUMBER_W-1:0] YEAR_START [ROM_YEARS] = '{
    17'h00000, 17'h0016D, 17'h002DA, 17'h00447, 17'h005B5, 17'h00722, 17'h0088F, 17'h009FC,
    17'h00B6A, 17'h00CD7, 17'h00E44, 17'h00FB1, 17'h0111F, 17'h0128C, 17'h013F9, 17'h01566,
    17'h016D4, 17'h01841, 17'h019AE, 17'h01B1B, 17'h01C89, 17'h01DF6, 17'h01F63, 17'h020D0,
    17'h0223E, 17'h023AB, 17'h02518, 17'h02685, 17'h027F3, 17'h02960, 17'h02ACD, 17'h02C3A,
    17'h02DA8, 17'h02F15, 17'h03082, 17'h031EF, 17'h0335D, 17'h034CA, 17'h03637, 17'h037A4,
    17'h03912, 17'h03A7F, 17'h03BEC, 17'h03D59, 17'h03EC7, 17'h04034, 17'h041A1, 17'h0430E,
    17'h0447C, 17'h045E9, 17'h04756, 17'h048C3, 17'h04A31, 17'h04B9E, 17'h04D0B, 17'h04E78,
    17'h04FE6, 17'h05153, 17'h052C0, 17'h0542D, 17'h0559B, 17'h05708, 17'h05875, 17'h059E2,
    17'h05B50, 17'h05CBD, 17'h05E2A, 17'h05F97, 17'h06105, 17'h06272, 17'h063DF, 17'h0654C,
    17'h066BA, 17'h06827, 17'h06994, 17'h06B01, 17'h06C6F, 17'h06DDC, 17'h06F49, 17'h070B6,
    17'h07224, 17'h07391, 17'h074FE, 17'h0766B, 17'h077D9, 17'h07946, 17'h07AB3, 17'h07C20,
    17'h07D8E, 17'h07EFB, 17'h08068, 17'h081D5, 17'h08343, 17'h084B0, 17'h0861D, 17'h0878A,
    17'h088F8, 17'h08A65, 17'h08BD2, 17'h08D3F, 17'h08EAD, 17'h0901A, 17'h09187, 17'h092F4,
    17'h09462, 17'h095CF, 17'h0973C, 17'h098A9, 17'h09A17, 17'h09B84, 17'h09CF1, 17'h09E5E,
    17'h09FCC, 17'h0A139, 17'h0A2A6, 17'h0A413, 17'h0A581, 17'h0A6EE, 17'h0A85B, 17'h0A9C8,
    17'h0AB36, 17'h0ACA3, 17'h0AE10, 17'h0AF7D, 17'h0B0EB, 17'h0B258, 17'h0B3C5, 17'h0B532,
    17'h0B6A0, 17'h0B80D, 17'h0B97A, 17'h0BAE7, 17'h0BC55, 17'h0BDC2, 17'h0BF2F, 17'h0C09C,
    17'h0C20A, 17'h0C377, 17'h0C4E4, 17'h0C651, 17'h0C7BF, 17'h0C92C, 17'h0CA99, 17'h0CC06,
    17'h0CD74, 17'h0CEE1, 17'h0D04E, 17'h0D1BB, 17'h0D329, 17'h0D496, 17'h0D603, 17'h0D770,
    17'h0D8DE, 17'h0DA4B, 17'h0DBB8, 17'h0DD25, 17'h0DE93, 17'h0E000, 17'h0E16D, 17'h0E2DA,
    17'h0E448, 17'h0E5B5, 17'h0E722, 17'h0E88F, 17'h0E9FD, 17'h0EB6A, 17'h0ECD7, 17'h0EE44,
    17'h0EFB2, 17'h0F11F, 17'h0F28C, 17'h0F3F9, 17'h0F567, 17'h0F6D4, 17'h0F841, 17'h0F9AE,
    17'h0FB1C, 17'h0FC89, 17'h0FDF6, 17'h0FF63, 17'h100D1, 17'h1023E, 17'h103AB, 17'h10518,
    17'h10686, 17'h107F3, 17'h10960, 17'h10ACD, 17'h10C3B, 17'h10DA8, 17'h10F15, 17'h11082,
    17'h111F0, 17'h1135D, 17'h114CA, 17'h11637, 17'h117A5, 17'h11912, 17'h11A7F, 17'h11BEC,
    17'h11D59, 17'h11EC6, 17'h12033, 17'h121A0, 17'h1230E, 17'h1247B, 17'h125E8, 17'h12755,
    17'h128C3, 17'h12A30, 17'h12B9D, 17'h12D0A, 17'h12E78, 17'h12FE5, 17'h13152, 17'h132BF,
    17'h1342D, 17'h1359A, 17'h13707, 17'h13874, 17'h139E2, 17'h13B4F, 17'h13CBC, 17'h13E29,
    17'h13F97, 17'h14104, 17'h14271, 17'h143DE, 17'h1454C, 17'h146B9, 17'h14826, 17'h14993,
    17'h14B01, 17'h14C6E, 17'h14DDB, 17'h14F48, 17'h150B6, 17'h15223, 17'h15390, 17'h154FD,
    17'h1566B, 17'h157D8, 17'h15945, 17'h15AB2, 17'h15C20, 17'h15D8D, 17'h15EFA, 17'h16067,
    17'h161D5, 17'h16342, 17'h164AF, 17'h1661C, 17'h1678A, 17'h168F7, 17'h16A64, 17'h16BD1
  };

endpackage

// ===== sv/dtdn_year_rom.sv =====
// ----------------------------------------------------------------------------
// dtdn_year_rom
// synchronous per-year start rom, registered read
// ----------------------------------------------------------------------------
module dtdn_year_rom import dtdn_pkg::*; (
  input  logic                clk,
  input  logic                rd_en,
  input  logic [ROM_AW-1:0]   addr,
  output logic [NUMBER_W-1:0] data
);

  always_ff @(posedge clk) begin
    if (rd_en) begin
      data <= YEAR_START[addr];
    end
  end

endmodule

// ===== sv/dtdn_check.sv =====
// ----------------------------------------------------------------------------
// dtdn_check
// date check, leap test and month offset, registered
// ----------------------------------------------------------------------------
module dtdn_check import dtdn_pkg::*; #(
  parameter int unsigned BASE_YEAR = DEF_BASE_YEAR,
  parameter int unsigned YEAR_SPAN = DEF_YEAR_SPAN
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               acc,
  input  logic [YEAR_W-1:0]  year,
  input  logic [MONTH_W-1:0] month,
  input  logic [DAY_W-1:0]   day,
  output logic [ROM_AW-1:0]  rom_addr,
  output chk_t               chk
);

  localparam logic [YEAR_W-1:0] BASE_V = YEAR_W'(BASE_YEAR);
  localparam logic [YEAR_W-1:0] SPAN_V = YEAR_W'(YEAR_SPAN);
  localparam logic [YEAR_W-1:0] ROM_V  = YEAR_W'(ROM_YEARS);

  logic [YEAR_W-1:0]   off;
  logic [24:0]         prod;
  logic [7:0]          q25;
  logic [YEAR_W-1:0]   r25;
  logic                leap;
  logic [DAY_W-1:0]    lim;
  logic                ok;
  logic                leap_add;
  logic [MSTART_W-1:0] mstart;

  always_comb begin
    off  = year - BASE_V;
    // year mod 25 via reciprocal
    prod = {13'd0, year} * {12'd0, RECIP_25};
    q25  = prod[RECIP_SH +: 8];
    r25  = year - YEAR_W'({4'd0, q25} * {7'd0, DIVISOR_25});
    // divisible by 4 and not by 100, or by 400
    leap = (year[1:0] == 2'd0) && ((r25 != '0) || (year[3:0] == 4'd0));
    lim  = month_len(month) + DAY_W'((month == MONTH_FEB) && leap);
    ok   = (day != '0) && (month >= MONTH_JAN) && (month <= MONTH_DEC) &&
           (year >= BASE_V) && (day <= lim) && (off < SPAN_V) && (off < ROM_V);
    leap_add = (month > MONTH_FEB) && leap;
    mstart   = month_start(month) + MSTART_W'(leap_add);
  end

  assign rom_addr = off[ROM_AW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      chk.valid <= 1'b0;
    end else begin
      chk.valid <= acc;
    end
    if (acc) begin
      chk.ok     <= ok;
      chk.mstart <= mstart;
      chk.day    <= day;
    end
  end

endmodule

// ===== sv/dtdn_sum.sv =====
// ----------------------------------------------------------------------------
// dtdn_sum
// final add of year, month and day parts into the result register
// ----------------------------------------------------------------------------
module dtdn_sum import dtdn_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  chk_t                chk,
  input  logic [NUMBER_W-1:0] rom_data,
  output logic                strobe,
  output logic [NUMBER_W-1:0] day_number,
  output logic                date_valid
);

  logic [NUMBER_W-1:0] total;
  logic                good;

  assign total = rom_data + NUMBER_W'(chk.mstart) + NUMBER_W'(chk.day);
  assign good  = chk.valid && chk.ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe     <= 1'b0;
      date_valid <= 1'b0;
    end else begin
      strobe     <= chk.valid;
      date_valid <= good;
    end
  end

  always_ff @(posedge clk) begin
    day_number <= good ? total : '0;
  end

endmodule

// ===== sv/date_to_day_number.sv =====
// ----------------------------------------------------------------------------
// date_to_day_number
// calendar date to day serial number counted from the base year
// ----------------------------------------------------------------------------
//
//  channel   ports                         handshake
//  --------  ----------------------------  ---------------------------------
//  command   year, month, day              start high while busy low
//  result    day_number, date_valid        strobe high for one cycle
//
//  one word is taken every cycle while busy is low; its result is registered
//  in the check stage and the synchronous year rom read, then in the final add
//  busy is high only while rst is held; reset clears the pipeline valid
//  flags, the rom needs no clearing pass
//  the receiver cannot stall, so results never wait and nothing is dropped
//
module date_to_day_number import dtdn_pkg::*; #(
  parameter int unsigned BASE_YEAR = DEF_BASE_YEAR,
  parameter int unsigned YEAR_SPAN = DEF_YEAR_SPAN
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [YEAR_W-1:0]   year,
  input  logic [MONTH_W-1:0]  month,
  input  logic [DAY_W-1:0]    day,
  output logic                strobe,
  output logic [NUMBER_W-1:0] day_number,
  output logic                date_valid
);

`include "date_to_day_number_defines.svh"

  logic                acc;
  logic [ROM_AW-1:0]   rom_addr;
  logic [NUMBER_W-1:0] rom_data;
  chk_t                chk;

  // no back-pressure anywhere, so only reset holds off a word
  assign busy = rst;
  assign acc  = start && !busy;

  // stage one: check the date and look up the month offset
  dtdn_check #(
    .BASE_YEAR (BASE_YEAR),
    .YEAR_SPAN (YEAR_SPAN)
  ) u_check (
    .clk      (clk),
    .rst      (rst),
    .acc      (acc),
    .year     (year),
    .month    (month),
    .day      (day),
    .rom_addr (rom_addr),
    .chk      (chk)
  );

  // per-year start serial, read in parallel with the check
  dtdn_year_rom u_rom (
    .clk   (clk),
    .rd_en (acc),
    .addr  (rom_addr),
    .data  (rom_data)
  );

  // stage two: add the parts and register the result
  dtdn_sum u_sum (
    .clk        (clk),
    .rst        (rst),
    .chk        (chk),
    .rom_data   (rom_data),
    .strobe     (strobe),
    .day_number (day_number),
    .date_valid (date_valid)
  );

  // every result comes from an accepted word, through the check and sum stages
  `DTDN_CHECK_NOW(a_strobe_src, strobe, $past(acc, 2), "result without a command")
  // a rejected date reads as zero
  `DTDN_CHECK_NOW(a_zero_bad, strobe && !date_valid, day_number == '0, "nonzero bad day")
  // a month outside the calendar is always reported as invalid
  `DTDN_CHECK_AFTER2(a_bad_month, acc && ((month == '0) || (month > MONTH_DEC)),
                     strobe && !date_valid, "bad month passed")
  // the check stage flags a word in the cycle after it is taken
  `DTDN_CHECK_NEXT(a_chk_valid, acc, chk.valid, "check stage lost a word")

endmodule
